// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// No dependencies; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define LOBM_CHK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define LOBM_CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/lobm_pkg.sv
// Shared types, constants and helpers of the limit order book matcher.
// No dependencies; used by lobm_ctrl, lobm_dp and the top level.
package lobm_pkg;

    localparam int PW   = 16;   // price width
    localparam int QW   = 20;   // order quantity width
    localparam int TMW  = 32;   // arrival time width
    localparam int OQW  = 25;   // reported quantity width
    localparam logic [OQW-1:0] QMAX = '1;

    // One resting order as it sits in book memory.
    typedef struct packed {
        logic [PW-1:0]  price;
        logic [QW-1:0]  qty;
        logic [TMW-1:0] tm;
    } t_entry;

    // One result transaction.
    typedef struct packed {
        logic [PW-1:0]  ask_px;
        logic [OQW-1:0] ask_qty;
        logic           ask_valid;
        logic [PW-1:0]  bid_px;
        logic [OQW-1:0] bid_qty;
        logic           bid_valid;
        logic [PW-1:0]  fill_px;
        logic [OQW-1:0] fill_qty;
        logic           fill_valid;
        logic           short_fill;
        logic           book_full;
        logic           last;
    } t_result;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SW_CHK, S_SW_RD, S_SW_TAKE, S_SW_NEXT, S_SW_NEXT2,
        S_SW_EMIT, S_SW_END, S_LV_INIT, S_LV_RD, S_LV_EV, S_LV_END, S_RS_START,
        S_RS_RD, S_RS_EV, S_SH_CHK, S_SH_WR, S_INS, S_RS_EMIT, S_FINISH
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_RD_HEAD, OP_TAKE, OP_RD_J, OP_LV_INIT, OP_LV_STEP,
        OP_LV_SET, OP_RS_INIT, OP_RS_FOUND, OP_J_INC, OP_SH_RD, OP_SH_WR, OP_INS,
        OP_EMIT_FILL, OP_EMIT_QUOTE, OP_EMIT_FULL, OP_FLUSH
    } t_op;

    // Command from the controller: operation and book select (1 = own side).
    typedef struct packed {
        t_op  op;
        logic own;
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic qzero;
        logic market;
        logic rem_zero;
        logic sw_go;
        logic removed;
        logic opp_empty;
        logic same_price;
        logic acc_nz;
        logic own_full;
        logic found;
        logic j_eq_pos;
        logic lv_more;
        logic bcast;
    } t_stat;

    // True when price a is strictly better than b on side s (1 bid, 0 ask).
    function automatic logic better(input logic s, input logic [PW-1:0] a,
                                    input logic [PW-1:0] b);
        return s ? (a > b) : (a < b);
    endfunction

endpackage

// File: rtl/limit_order_book_matcher.sv
// Limit order book matcher for one instrument, price-time priority.
// An order is taken when start is high and busy is low. Each result
// transaction appears for exactly one cycle with o_strobe high and cannot be
// held off; o_last marks the final result of an order. Busy stays high
// while the order sweeps the opposite side, rescans any emptied price level
// and rests or drops its remainder; the single book-memory port, used at
// most once per cycle, paces this work. Each result is registered out in
// the cycle after the next one is formed, or after the order's final state.
// No clearing pass is needed.
// Depends on lobm_pkg, lobm_ctrl, lobm_dp and assert_macros.svh.
`include "assert_macros.svh"
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_command,
    input  logic                          i_side,
    input  logic [lobm_pkg::PW-1:0]       i_limit_price,
    input  logic [lobm_pkg::QW-1:0]       i_order_quantity,
    input  logic [lobm_pkg::TMW-1:0]      i_arrival_time,
    output logic                          o_strobe,
    output logic [lobm_pkg::PW-1:0]       o_ask_price,
    output logic [lobm_pkg::OQW-1:0]      o_ask_quantity,
    output logic                          o_ask_valid,
    output logic [lobm_pkg::PW-1:0]       o_bid_price,
    output logic [lobm_pkg::OQW-1:0]      o_bid_quantity,
    output logic                          o_bid_valid,
    output logic [lobm_pkg::PW-1:0]       o_fill_price,
    output logic [lobm_pkg::OQW-1:0]      o_fill_quantity,
    output logic                          o_fill_valid,
    output logic                          o_short_fill,
    output logic                          o_book_full,
    output logic                          o_last
);

    lobm_pkg::t_cmd    s_cmd;
    lobm_pkg::t_stat   s_stat;
    lobm_pkg::t_result s_res;

    // Controller.
    lobm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd),
        .o_busy  (busy)
    );

    // Datapath.
    lobm_dp #(.BOOK_DEPTH(BOOK_DEPTH)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (s_cmd),
        .i_command        (i_command),
        .i_side           (i_side),
        .i_limit_price    (i_limit_price),
        .i_order_quantity (i_order_quantity),
        .i_arrival_time   (i_arrival_time),
        .o_stat           (s_stat),
        .o_result         (s_res),
        .o_strobe         (o_strobe)
    );

    // Result fields.
    assign o_ask_price     = s_res.ask_px;
    assign o_ask_quantity  = s_res.ask_qty;
    assign o_ask_valid     = s_res.ask_valid;
    assign o_bid_price     = s_res.bid_px;
    assign o_bid_quantity  = s_res.bid_qty;
    assign o_bid_valid     = s_res.bid_valid;
    assign o_fill_price    = s_res.fill_px;
    assign o_fill_quantity = s_res.fill_qty;
    assign o_fill_valid    = s_res.fill_valid;
    assign o_short_fill    = s_res.short_fill;
    assign o_book_full     = s_res.book_full;
    assign o_last          = s_res.last;

    // Checks on the block's own logic.
    `LOBM_CHK_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `LOBM_CHK_NOW(a_idle_last, i_clk, i_rst_n, o_strobe && !busy, o_last, "idle result not last")
    `LOBM_CHK_NOW(a_fill_nz, i_clk, i_rst_n, o_strobe && o_fill_valid, o_fill_quantity != '0, "zero fill")
    `LOBM_CHK_NOW(a_full_last, i_clk, i_rst_n, o_strobe && o_book_full, o_last && !o_fill_valid, "bad full")

endmodule

// File: rtl/lobm_ctrl.sv
// Controller state machine of the limit order book matcher.
// Depends on lobm_pkg; drives lobm_dp through command and status structs.
module lobm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lobm_pkg::t_stat i_stat,
    output lobm_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    lobm_pkg::t_state r_state, n_state;
    logic             r_ph, n_ph;   // level scan return: 0 sweep, 1 rest

    // State and phase registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lobm_pkg::S_IDLE;
            r_ph    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_start) n_state = lobm_pkg::S_DISPATCH;
            end
            lobm_pkg::S_DISPATCH: begin
                if (i_stat.qzero) n_state = lobm_pkg::S_FINISH;
                else if (i_stat.market && i_stat.rem_zero) n_state = lobm_pkg::S_FINISH;
                else n_state = lobm_pkg::S_SW_CHK;
            end
            lobm_pkg::S_SW_CHK: begin
                n_state = i_stat.sw_go ? lobm_pkg::S_SW_RD : lobm_pkg::S_SW_END;
            end
            lobm_pkg::S_SW_RD: n_state = lobm_pkg::S_SW_TAKE;
            lobm_pkg::S_SW_TAKE: begin
                n_state = i_stat.removed ? lobm_pkg::S_SW_NEXT : lobm_pkg::S_SW_CHK;
            end
            lobm_pkg::S_SW_NEXT: begin
                n_state = i_stat.opp_empty ? lobm_pkg::S_SW_EMIT : lobm_pkg::S_SW_NEXT2;
            end
            lobm_pkg::S_SW_NEXT2: begin
                if (i_stat.same_price) begin
                    n_state = lobm_pkg::S_SW_CHK;
                end else begin
                    n_state = lobm_pkg::S_LV_INIT;
                    n_ph    = 1'b0;
                end
            end
            lobm_pkg::S_SW_EMIT: n_state = lobm_pkg::S_SW_CHK;
            lobm_pkg::S_SW_END: begin
                if (i_stat.market || i_stat.rem_zero) n_state = lobm_pkg::S_FINISH;
                else n_state = lobm_pkg::S_RS_START;
            end
            lobm_pkg::S_LV_INIT: n_state = lobm_pkg::S_LV_RD;
            lobm_pkg::S_LV_RD:   n_state = lobm_pkg::S_LV_EV;
            lobm_pkg::S_LV_EV: begin
                n_state = i_stat.lv_more ? lobm_pkg::S_LV_RD : lobm_pkg::S_LV_END;
            end
            lobm_pkg::S_LV_END: begin
                n_state = r_ph ? lobm_pkg::S_RS_EMIT : lobm_pkg::S_SW_EMIT;
            end
            lobm_pkg::S_RS_START: begin
                n_state = i_stat.own_full ? lobm_pkg::S_FINISH : lobm_pkg::S_RS_RD;
            end
            lobm_pkg::S_RS_RD: n_state = lobm_pkg::S_RS_EV;
            lobm_pkg::S_RS_EV: begin
                n_state = i_stat.found ? lobm_pkg::S_SH_CHK : lobm_pkg::S_RS_RD;
            end
            lobm_pkg::S_SH_CHK: begin
                n_state = i_stat.j_eq_pos ? lobm_pkg::S_INS : lobm_pkg::S_SH_WR;
            end
            lobm_pkg::S_SH_WR: n_state = lobm_pkg::S_SH_CHK;
            lobm_pkg::S_INS: begin
                n_state = lobm_pkg::S_LV_INIT;
                n_ph    = 1'b1;
            end
            lobm_pkg::S_RS_EMIT: n_state = lobm_pkg::S_FINISH;
            lobm_pkg::S_FINISH:  n_state = lobm_pkg::S_IDLE;
            default:             n_state = lobm_pkg::S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd.op  = lobm_pkg::OP_NONE;
        o_cmd.own = 1'b0;
        case (r_state)
            lobm_pkg::S_IDLE: begin
                if (i_start) o_cmd.op = lobm_pkg::OP_LOAD;
            end
            lobm_pkg::S_DISPATCH: begin
                if (!i_stat.qzero && i_stat.market && i_stat.rem_zero)
                    o_cmd.op = lobm_pkg::OP_EMIT_QUOTE;
            end
            lobm_pkg::S_SW_RD:   o_cmd.op = lobm_pkg::OP_RD_HEAD;
            lobm_pkg::S_SW_TAKE: o_cmd.op = lobm_pkg::OP_TAKE;
            lobm_pkg::S_SW_NEXT: begin
                if (!i_stat.opp_empty) o_cmd.op = lobm_pkg::OP_RD_HEAD;
            end
            lobm_pkg::S_SW_EMIT: o_cmd.op = lobm_pkg::OP_EMIT_FILL;
            lobm_pkg::S_SW_END: begin
                if (i_stat.acc_nz) o_cmd.op = lobm_pkg::OP_EMIT_FILL;
            end
            lobm_pkg::S_LV_INIT: begin
                o_cmd.op  = lobm_pkg::OP_LV_INIT;
                o_cmd.own = r_ph;
            end
            lobm_pkg::S_LV_RD: begin
                o_cmd.op  = lobm_pkg::OP_RD_J;
                o_cmd.own = r_ph;
            end
            lobm_pkg::S_LV_EV:  o_cmd.op = lobm_pkg::OP_LV_STEP;
            lobm_pkg::S_LV_END: o_cmd.op = lobm_pkg::OP_LV_SET;
            lobm_pkg::S_RS_START: begin
                o_cmd.own = 1'b1;
                o_cmd.op  = i_stat.own_full ? lobm_pkg::OP_EMIT_FULL : lobm_pkg::OP_RS_INIT;
            end
            lobm_pkg::S_RS_RD: begin
                o_cmd.op  = lobm_pkg::OP_RD_J;
                o_cmd.own = 1'b1;
            end
            lobm_pkg::S_RS_EV: begin
                o_cmd.op = i_stat.found ? lobm_pkg::OP_RS_FOUND : lobm_pkg::OP_J_INC;
            end
            lobm_pkg::S_SH_CHK: begin
                o_cmd.own = 1'b1;
                if (!i_stat.j_eq_pos) o_cmd.op = lobm_pkg::OP_SH_RD;
            end
            lobm_pkg::S_SH_WR: begin
                o_cmd.op  = lobm_pkg::OP_SH_WR;
                o_cmd.own = 1'b1;
            end
            lobm_pkg::S_INS: begin
                o_cmd.op  = lobm_pkg::OP_INS;
                o_cmd.own = 1'b1;
            end
            lobm_pkg::S_RS_EMIT: begin
                if (i_stat.bcast) o_cmd.op = lobm_pkg::OP_EMIT_QUOTE;
            end
            lobm_pkg::S_FINISH: o_cmd.op = lobm_pkg::OP_FLUSH;
            default:            o_cmd.op = lobm_pkg::OP_NONE;
        endcase
    end

    assign o_busy = (r_state != lobm_pkg::S_IDLE);

endmodule

// File: rtl/lobm_dp.sv
// Datapath of the limit order book matcher: book memory, per-side
// registers, order registers and the result pipeline. Depends on lobm_pkg.
module lobm_dp #(
    parameter int BOOK_DEPTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lobm_pkg::t_cmd                i_cmd,
    input  logic                          i_command,
    input  logic                          i_side,
    input  logic [lobm_pkg::PW-1:0]       i_limit_price,
    input  logic [lobm_pkg::QW-1:0]       i_order_quantity,
    input  logic [lobm_pkg::TMW-1:0]      i_arrival_time,
    output lobm_pkg::t_stat               o_stat,
    output lobm_pkg::t_result             o_result,
    output logic                          o_strobe
);

    localparam int AW  = $clog2(BOOK_DEPTH);
    localparam int CNW = AW + 1;
    localparam int TW  = lobm_pkg::QW + AW;
    localparam int CW  = (TW > lobm_pkg::OQW) ? TW : lobm_pkg::OQW;
    localparam logic [CNW-1:0] DEPTH_C = CNW'(BOOK_DEPTH);

    // Book memory: both sides, each a circular buffer in priority order.
    lobm_pkg::t_entry r_mem [0:(2 << AW)-1];
    lobm_pkg::t_entry r_rd;

    // Per-side book registers (index 0 ask, 1 bid).
    logic [AW-1:0]            r_head [2];
    logic [CNW-1:0]           r_cnt  [2];
    logic [TW-1:0]            r_tot  [2];
    logic [TW-1:0]            r_lvl  [2];
    logic [lobm_pkg::PW-1:0]  r_bp   [2];

    // Order and working registers.
    logic                     r_cmd, r_side, r_qzero, r_sf, r_lsd, r_wv;
    logic [lobm_pkg::PW-1:0]  r_lim, r_fp, r_sbp, r_wb;
    logic [lobm_pkg::QW-1:0]  r_rem, r_acc;
    logic [lobm_pkg::TMW-1:0] r_tm;
    logic [CNW-1:0]           r_j, r_pos;
    logic [TW-1:0]            r_sacc;

    // Result pipeline: one result held back so the final one can carry last.
    lobm_pkg::t_result        r_pend, r_out;
    logic                     r_pend_v, r_out_v;

    logic                     s_sel, s_opp, s_rd_en, s_wr_en, s_emit;
    logic [CNW-1:0]           s_off, s_sum;
    logic [AW:0]              s_addr;
    logic [lobm_pkg::QW-1:0]  s_take;
    lobm_pkg::t_entry         s_wdata;
    lobm_pkg::t_result        s_res, s_last;

    function automatic logic [lobm_pkg::OQW-1:0] sat_q(input logic [TW-1:0] v);
        return (CW'(v) > CW'(lobm_pkg::QMAX)) ? lobm_pkg::QMAX : lobm_pkg::OQW'(v);
    endfunction

    assign s_opp = ~r_side;

    // Memory address: head of the selected side plus an offset, wrapped.
    always_comb begin
        s_sel = i_cmd.own ? r_side : s_opp;
        case (i_cmd.op)
            lobm_pkg::OP_SH_RD:                    s_off = r_j - CNW'(1);
            lobm_pkg::OP_INS:                      s_off = r_pos;
            lobm_pkg::OP_RD_HEAD, lobm_pkg::OP_TAKE: s_off = '0;
            default:                               s_off = r_j;
        endcase
        s_sum = CNW'(r_head[s_sel]) + s_off;
        if (s_sum >= DEPTH_C) s_sum = s_sum - DEPTH_C;
        s_addr = {s_sel, s_sum[AW-1:0]};
    end

    // Fill amount at the head and memory write data.
    always_comb begin
        s_take  = (r_rd.qty <= r_rem) ? r_rd.qty : r_rem;
        s_rd_en = (i_cmd.op == lobm_pkg::OP_RD_HEAD) || (i_cmd.op == lobm_pkg::OP_RD_J) ||
                  (i_cmd.op == lobm_pkg::OP_SH_RD);
        s_wr_en = 1'b0;
        s_wdata = r_rd;
        case (i_cmd.op)
            lobm_pkg::OP_TAKE: begin
                s_wr_en      = !(r_rd.qty <= r_rem);
                s_wdata.qty  = r_rd.qty - r_rem;
            end
            lobm_pkg::OP_SH_WR: s_wr_en = 1'b1;
            lobm_pkg::OP_INS: begin
                s_wr_en = 1'b1;
                s_wdata = '{price: r_lim, qty: r_rem, tm: r_tm};
            end
            default: s_wr_en = 1'b0;
        endcase
    end

    // Book memory port: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (s_wr_en) r_mem[s_addr] <= s_wdata;
        if (s_rd_en) r_rd <= r_mem[s_addr];
    end

    // Result built from the current quotes, and the held result marked last.
    always_comb begin
        s_res = '0;
        s_res.ask_valid  = (r_cnt[0] != '0);
        s_res.ask_px     = s_res.ask_valid ? r_bp[0] : '0;
        s_res.ask_qty    = s_res.ask_valid ? sat_q(r_lvl[0]) : '0;
        s_res.bid_valid  = (r_cnt[1] != '0);
        s_res.bid_px     = s_res.bid_valid ? r_bp[1] : '0;
        s_res.bid_qty    = s_res.bid_valid ? sat_q(r_lvl[1]) : '0;
        s_res.short_fill = r_sf;
        s_res.book_full  = (i_cmd.op == lobm_pkg::OP_EMIT_FULL);
        if (i_cmd.op == lobm_pkg::OP_EMIT_FILL) begin
            s_res.fill_valid = 1'b1;
            s_res.fill_px    = r_fp;
            s_res.fill_qty   = lobm_pkg::OQW'(r_acc);
        end
        s_emit = (i_cmd.op == lobm_pkg::OP_EMIT_FILL) ||
                 (i_cmd.op == lobm_pkg::OP_EMIT_QUOTE) ||
                 (i_cmd.op == lobm_pkg::OP_EMIT_FULL);
        s_last      = r_pend;
        s_last.last = 1'b1;
    end

    // Book registers and sequencing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
                r_tot[k]  <= '0;
                r_lvl[k]  <= '0;
                r_bp[k]   <= '0;
            end
            r_sf <= 1'b0;
        end else begin
            case (i_cmd.op)
                lobm_pkg::OP_LOAD: begin
                    r_cmd   <= i_command;
                    r_side  <= i_side;
                    r_lim   <= i_limit_price;
                    r_tm    <= i_arrival_time;
                    r_acc   <= '0;
                    r_qzero <= (i_order_quantity == '0);
                    if (i_command && (CW'(i_order_quantity) > CW'(r_tot[~i_side]))) begin
                        r_sf  <= 1'b1;
                        r_rem <= lobm_pkg::QW'(r_tot[~i_side]);
                    end else begin
                        r_sf  <= 1'b0;
                        r_rem <= i_order_quantity;
                    end
                end
                lobm_pkg::OP_TAKE: begin
                    r_rem        <= r_rem - s_take;
                    r_acc        <= r_acc + s_take;
                    r_fp         <= r_rd.price;
                    r_tot[s_opp] <= r_tot[s_opp] - TW'(s_take);
                    r_lvl[s_opp] <= r_lvl[s_opp] - TW'(s_take);
                    if (r_rd.qty <= r_rem) begin
                        r_head[s_opp] <= (r_head[s_opp] == AW'(BOOK_DEPTH - 1)) ?
                                         '0 : r_head[s_opp] + AW'(1);
                        r_cnt[s_opp]  <= r_cnt[s_opp] - CNW'(1);
                    end
                end
                lobm_pkg::OP_LV_INIT: begin
                    r_lsd  <= s_sel;
                    r_j    <= '0;
                    r_sacc <= '0;
                    r_sbp  <= '0;
                end
                lobm_pkg::OP_LV_STEP: begin
                    if (o_stat.lv_more) begin
                        r_sacc <= r_sacc + TW'(r_rd.qty);
                        if (r_j == '0) r_sbp <= r_rd.price;
                        r_j <= r_j + CNW'(1);
                    end
                end
                lobm_pkg::OP_LV_SET: begin
                    r_lvl[r_lsd] <= r_sacc;
                    r_bp[r_lsd]  <= r_sbp;
                end
                lobm_pkg::OP_RS_INIT: begin
                    r_j  <= '0;
                    r_wv <= (r_cnt[r_side] != '0);
                    r_wb <= r_bp[r_side];
                end
                lobm_pkg::OP_RS_FOUND: begin
                    r_pos <= r_j;
                    r_j   <= r_cnt[r_side];
                end
                lobm_pkg::OP_J_INC: r_j <= r_j + CNW'(1);
                lobm_pkg::OP_SH_WR: r_j <= r_j - CNW'(1);
                lobm_pkg::OP_INS: begin
                    r_cnt[r_side] <= r_cnt[r_side] + CNW'(1);
                    r_tot[r_side] <= r_tot[r_side] + TW'(r_rem);
                end
                lobm_pkg::OP_EMIT_FILL: r_acc <= '0;
                default: ;
            endcase
        end
    end

    // Result transactions: the previous result goes out when a new one is
    // made; the held one goes out marked last when the order finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= 1'b0;
            if (s_emit) begin
                if (r_pend_v) begin
                    r_out   <= r_pend;
                    r_out_v <= 1'b1;
                end
                r_pend   <= s_res;
                r_pend_v <= 1'b1;
            end else if (i_cmd.op == lobm_pkg::OP_FLUSH && r_pend_v) begin
                r_out    <= s_last;
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.qzero      = r_qzero;
        o_stat.market     = r_cmd;
        o_stat.rem_zero   = (r_rem == '0);
        o_stat.sw_go      = (r_rem != '0) && (r_cnt[s_opp] != '0) &&
                            (r_cmd || !lobm_pkg::better(s_opp, r_lim, r_bp[s_opp]));
        o_stat.removed    = (r_rd.qty <= r_rem);
        o_stat.opp_empty  = (r_cnt[s_opp] == '0);
        o_stat.same_price = (r_rd.price == r_fp);
        o_stat.acc_nz     = (r_acc != '0);
        o_stat.own_full   = (r_cnt[r_side] == DEPTH_C);
        o_stat.found      = (r_j == r_cnt[r_side]) ||
                            lobm_pkg::better(r_side, r_lim, r_rd.price) ||
                            ((r_rd.price == r_lim) && (r_rd.tm > r_tm));
        o_stat.j_eq_pos   = (r_j == r_pos);
        o_stat.lv_more    = (r_j < r_cnt[r_lsd]) && ((r_j == '0) || (r_rd.price == r_sbp));
        o_stat.bcast      = !r_wv || !lobm_pkg::better(r_side, r_wb, r_lim);
    end

    assign o_result = r_out;
    assign o_strobe = r_out_v;

endmodule
